// ===== sv/cgp_pkg.sv =====
// Shared types and constants for the core gating policy block.
`timescale 1ns / 1ps
`default_nettype none
package cgp_pkg;

	localparam int CNT_W    = 6;
	localparam int NUM_W    = 2;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CNT_W-1:0] CNT_MAX        = 6'd63;
	localparam logic [NUM_W-1:0] NUM_MAX        = 2'd3;
	localparam logic             ENABLE_RST     = 1'b1;
	localparam logic [CNT_W-1:0] THRESHOLD_RST  = 6'd30;

	localparam logic REG_ENABLE    = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAKE,
		ST_PARK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic wake_step;
		logic park_step;
		logic idx_one;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/cgp_regs.sv =====
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
`default_nettype none
module cgp_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cgp_pkg::APB_AW-1:0] paddr,
	input  wire logic [cgp_pkg::APB_DW-1:0] pwdata,
	output logic      [cgp_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output logic                            enable,
	output logic      [cgp_pkg::CNT_W-1:0]  threshold
);
	import cgp_pkg::*;

	logic             enable_q;
	logic [CNT_W-1:0] threshold_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_ENABLE:    enable_q    <= pwdata[0];
				REG_THRESHOLD: threshold_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ENABLE:    prdata = APB_DW'(enable_q);
			REG_THRESHOLD: prdata = APB_DW'(threshold_q);
			default:       prdata = '0;
		endcase
	end

	assign enable    = enable_q;
	assign threshold = threshold_q;

endmodule
`default_nettype wire

// ===== sv/cgp_ctrl.sv =====
// Controller state machine sequencing the wake and park walks.
`timescale 1ns / 1ps
`default_nettype none
module cgp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire cgp_pkg::status_t st,
	output cgp_pkg::cmd_t         cmd
);
	import cgp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_WAKE;
				end
			end
			ST_WAKE: begin
				if (st.idx_last) begin
					cmd.idx_one = 1'b1;
					state_d     = ST_PARK;
				end else begin
					cmd.wake_step = 1'b1;
				end
			end
			ST_PARK: begin
				cmd.park_step = 1'b1;
				if (st.idx_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/cgp_dp.sv =====
// Datapath: online mask, park counters, walk index and output register.
`timescale 1ns / 1ps
`default_nettype none
module cgp_dp #(
	parameter int NUM_CORES = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cgp_pkg::cmd_t             cmd,
	output cgp_pkg::status_t               st,
	input  wire logic                      enable,
	input  wire logic [cgp_pkg::CNT_W-1:0] threshold,
	input  wire logic [NUM_CORES-1:0]      at_max_mask,
	input  wire logic [NUM_CORES-1:0]      at_min_mask,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [NUM_CORES-1:0]      online_mask,
	output logic      [cgp_pkg::NUM_W-1:0] cores_woken,
	output logic      [cgp_pkg::NUM_W-1:0] cores_parked
);
	import cgp_pkg::*;

	localparam int IW = $clog2(NUM_CORES);

	logic [NUM_CORES-1:0] mask_q;
	logic [CNT_W-1:0]     cnt_q [NUM_CORES];
	logic [IW-1:0]        idx_q;
	logic [NUM_CORES-1:0] amax_q, amin_q;
	logic                 wake_en_q, park_en_q;
	logic [NUM_W-1:0]     woken_q, parked_q;

	logic                 ov_q;
	logic [NUM_CORES-1:0] out_mask_q;
	logic [NUM_W-1:0]     out_woken_q, out_parked_q;

	logic          lo_found, hi_found;
	logic [IW-1:0] lo_idx, hi_idx;
	logic          idx_last, wake_do, park_hit, park_do;

	// Lowest offline core and highest online core, core 0 excluded.
	always_comb begin
		lo_found = 1'b0;
		lo_idx   = '0;
		for (int i = NUM_CORES - 1; i >= 1; i--) begin
			if (!mask_q[i]) begin
				lo_found = 1'b1;
				lo_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		hi_found = 1'b0;
		hi_idx   = '0;
		for (int i = 1; i < NUM_CORES; i++) begin
			if (mask_q[i]) begin
				hi_found = 1'b1;
				hi_idx   = IW'(i);
			end
		end
	end

	assign idx_last = (idx_q == IW'(NUM_CORES - 1));
	assign wake_do  = cmd.wake_step && wake_en_q && mask_q[idx_q] && amax_q[idx_q]
		&& !idx_last && lo_found;
	assign park_hit = cmd.park_step && park_en_q && mask_q[idx_q] && amin_q[idx_q]
		&& hi_found;
	assign park_do  = park_hit && (cnt_q[hi_idx] > threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= NUM_CORES'(1);
			for (int i = 0; i < NUM_CORES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (wake_do) begin
				mask_q[lo_idx] <= 1'b1;
				cnt_q[lo_idx]  <= '0;
			end else if (park_do) begin
				mask_q[hi_idx] <= 1'b0;
				cnt_q[hi_idx]  <= '0;
			end else if (park_hit && cnt_q[hi_idx] != CNT_MAX) begin
				cnt_q[hi_idx] <= cnt_q[hi_idx] + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			wake_en_q <= 1'b0;
			park_en_q <= 1'b0;
			woken_q   <= '0;
			parked_q  <= '0;
		end else begin
			if (cmd.start) begin
				idx_q     <= '0;
				wake_en_q <= enable && !(&mask_q);
				park_en_q <= enable && (mask_q[NUM_CORES-1:1] != '0);
				woken_q   <= '0;
				parked_q  <= '0;
			end else if (cmd.idx_one) begin
				idx_q <= IW'(1);
			end else if (cmd.wake_step || cmd.park_step) begin
				idx_q <= idx_q + IW'(1);
			end
			if (wake_do && woken_q != NUM_MAX) begin
				woken_q <= woken_q + NUM_W'(1);
			end
			if (park_do && parked_q != NUM_MAX) begin
				parked_q <= parked_q + NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			amax_q <= at_max_mask;
			amin_q <= at_min_mask;
		end
		if (cmd.load_out) begin
			out_mask_q   <= mask_q;
			out_woken_q  <= woken_q;
			out_parked_q <= parked_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_out) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	assign st.idx_last = idx_last;
	assign st.out_free = !ov_q || out_ready;

	assign out_valid    = ov_q;
	assign online_mask  = out_mask_q;
	assign cores_woken  = out_woken_q;
	assign cores_parked = out_parked_q;

endmodule
`default_nettype wire

// ===== sv/core_gating_policy.sv =====
// Top level of the core gating policy block.
`timescale 1ns / 1ps
`default_nettype none
// Each transfer on the slave stream is one sampling tick carrying the per-core
// at-maximum and at-minimum frequency masks. Each tick yields exactly one
// transfer on the master stream with the online mask after the tick and the
// number of cores woken and parked during it.
// The policy registers (enable at 0x0, park threshold at 0x4) are written
// through the APB port. The user writes them only while the block is idle;
// the block itself does not enforce this. A tick runs a wake walk over the
// cores, then a park walk over each core above core 0, and then loads the
// output register. The walk over the cores in the datapath sets the length
// of a tick, and the block works on one tick at a time: it takes no new tick
// before the current one has loaded its result.
// The output register lets the next tick be taken while a result waits.
// When the receiver stalls, the finished result of the following tick waits
// in the datapath, with the controller holding, until the output register
// is free.
// Reset brings only core 0 online, clears all park counters, sets enable to 1
// and the park threshold to 30.
module core_gating_policy #(
	parameter int NUM_CORES = 4
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      psel,
	input  wire logic                                      penable,
	input  wire logic                                      pwrite,
	input  wire logic [cgp_pkg::APB_AW-1:0]                paddr,
	input  wire logic [cgp_pkg::APB_DW-1:0]                pwdata,
	output logic      [cgp_pkg::APB_DW-1:0]                prdata,
	output logic                                           pready,
	input  wire logic                                      s_tvalid,
	output logic                                           s_tready,
	// Fields from bit 0: at_max_mask, at_min_mask.
	input  wire logic [((2*NUM_CORES+7)/8)*8-1:0]          s_tdata,
	output logic                                           m_tvalid,
	input  wire logic                                      m_tready,
	// Fields from bit 0: online_mask, cores_woken, cores_parked.
	output logic      [((NUM_CORES+2*cgp_pkg::NUM_W+7)/8)*8-1:0] m_tdata
);
	import cgp_pkg::*;

	localparam int OUT_W = ((NUM_CORES + 2 * NUM_W + 7) / 8) * 8;

	cmd_t             cmd;
	status_t          st;
	logic             enable;
	logic [CNT_W-1:0] threshold;
	logic [NUM_CORES-1:0] online_mask;
	logic [NUM_W-1:0]     cores_woken, cores_parked;

	cgp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.enable    (enable),
		.threshold (threshold)
	);

	cgp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	cgp_dp #(
		.NUM_CORES (NUM_CORES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.enable       (enable),
		.threshold    (threshold),
		.at_max_mask  (s_tdata[NUM_CORES-1:0]),
		.at_min_mask  (s_tdata[2*NUM_CORES-1:NUM_CORES]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.online_mask  (online_mask),
		.cores_woken  (cores_woken),
		.cores_parked (cores_parked)
	);

	assign m_tdata = OUT_W'({cores_parked, cores_woken, online_mask});

endmodule
`default_nettype wire

// ===== sv/cgp_checker.sv =====
// Port-level checker for the core gating policy block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module cgp_checker #(
	parameter int NUM_CORES = 4
) (
	input wire logic                                              clk,
	input wire logic                                              arst_n,
	input wire logic                                              s_tvalid,
	input wire logic                                              s_tready,
	input wire logic                                              m_tvalid,
	input wire logic                                              m_tready,
	input wire logic [((NUM_CORES+2*cgp_pkg::NUM_W+7)/8)*8-1:0]   m_tdata
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Core 0 is always reported online.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0])
		else $error("core 0 reported offline");

	// Only one tick is in work at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("tick accepted while another is in work");

	// A tick transfer never yields a result in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind core_gating_policy cgp_checker #(
	.NUM_CORES (NUM_CORES)
) u_cgp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_core_gating_policy.sv =====
// Self-checking testbench for core_gating_policy: stream ticks in, predicted results out.
`timescale 1ns / 1ps
module tb_core_gating_policy;
	import cgp_pkg::*;

	localparam int NC          = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 120;
	localparam logic [APB_AW-1:0] ADDR_ENABLE    = {REG_ENABLE, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};

	typedef struct packed {
		logic [NUM_W-1:0] parked;
		logic [NUM_W-1:0] woken;
		logic [NC-1:0]    online;
	} tick_result_t;

	class gating_scoreboard;
		logic             enable;
		logic [CNT_W-1:0] threshold;
		logic [NC-1:0]    online;
		logic [CNT_W-1:0] counter[NC];
		tick_result_t     expected_ticks[$];
		int               errors;

		function new();
			enable    = ENABLE_RST;
			threshold = THRESHOLD_RST;
			online    = NC'(1);
			foreach (counter[i]) counter[i] = '0;
			errors    = 0;
		endfunction

		function void apply_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
			if (addr == ADDR_ENABLE)
				enable = data[0];
			else if (addr == ADDR_THRESHOLD)
				threshold = data[CNT_W-1:0];
		endfunction

		function int wake_lowest();
			for (int c = 1; c < NC; c++) begin
				if (!online[c]) begin
					online[c]  = 1'b1;
					counter[c] = '0;
					return 1;
				end
			end
			return 0;
		endfunction

		function int park_highest();
			for (int c = NC - 1; c > 0; c--) begin
				if (online[c]) begin
					if (counter[c] > threshold) begin
						online[c]  = 1'b0;
						counter[c] = '0;
						return 1;
					end
					if (counter[c] < CNT_MAX)
						counter[c] = counter[c] + 1'b1;
					return 0;
				end
			end
			return 0;
		endfunction

		function void note_tick(logic [NC-1:0] at_max, logic [NC-1:0] at_min);
			int woken;
			int parked;
			int start_count;
			tick_result_t r;
			woken  = 0;
			parked = 0;
			online[0] = 1'b1;
			if (enable) begin
				start_count = $countones(online);
				if (start_count < NC) begin
					for (int c = 0; c < NC - 1; c++)
						if (online[c] && at_max[c])
							woken += wake_lowest();
				end
				if (start_count > 1) begin
					for (int c = 1; c < NC; c++)
						if (online[c] && at_min[c])
							parked += park_highest();
				end
			end
			if (woken > NUM_MAX)
				woken = NUM_MAX;
			if (parked > NUM_MAX)
				parked = NUM_MAX;
			r.online = online;
			r.woken  = NUM_W'(woken);
			r.parked = NUM_W'(parked);
			expected_ticks.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_ticks.pop_front();
			if (got.online !== want.online) begin
				$display("%0t: online_mask expected %h actual %h", $time, want.online, got.online);
				errors++;
			end
			if (got.woken !== want.woken) begin
				$display("%0t: cores_woken expected %0d actual %0d", $time, want.woken, got.woken);
				errors++;
			end
			if (got.parked !== want.parked) begin
				$display("%0t: cores_parked expected %0d actual %0d", $time, want.parked,
					got.parked);
				errors++;
			end
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;

	logic no_idle;
	logic long_hold;
	int   cycles;

	gating_scoreboard sb;

	core_gating_policy #(.NUM_CORES(NC)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_core_gating_policy NOT OK");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(tick_result_t'(m_tdata));
		end
	end

	task automatic send_tick(input logic [NC-1:0] at_max, input logic [NC-1:0] at_min);
		int gap;
		gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {at_min, at_max};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(at_max, at_min);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.apply_write(addr, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_threshold(input int thr);
		apb_write(ADDR_THRESHOLD, ($urandom() & ~32'h3F) | APB_DW'(thr));
	endtask

	task automatic set_enable(input logic en);
		apb_write(ADDR_ENABLE, ($urandom() & ~32'h1) | APB_DW'(en));
	endtask

	task automatic run_random(input int n);
		int left;
		int style;
		int seg;
		logic [NC-1:0] mx;
		logic [NC-1:0] mn;
		left = n;
		while (left > 0) begin
			style = $urandom_range(0, 9);
			seg   = $urandom_range(10, 60);
			if (seg > left)
				seg = left;
			repeat (seg) begin
				if (style < 4) begin
					mx = ($urandom_range(0, 5) == 0) ? NC'($urandom) : '0;
					mn = ($urandom_range(0, 2) == 0) ? NC'($urandom) : '1;
				end else if (style < 7) begin
					mx = NC'($urandom) | NC'(1);
					mn = ($urandom_range(0, 3) == 0) ? NC'($urandom) : '0;
				end else begin
					mx = NC'($urandom);
					mn = NC'($urandom);
				end
				send_tick(mx, mn);
			end
			left -= seg;
		end
	endtask

	initial begin
		sb        = new();
		no_idle   = 1'b0;
		long_hold = 1'b0;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_tick(4'h0, 4'h0);
		send_tick(4'hF, 4'h0);
		send_tick(4'h0, 4'hF);
		send_tick(4'hF, 4'hF);
		send_tick(4'h8, 4'h0);
		set_threshold(0);
		send_tick(4'h0, 4'hF);
		send_tick(4'h0, 4'hF);
		send_tick(4'h0, 4'h2);
		send_tick(4'h0, 4'h2);
		send_tick(4'h0, 4'hF);
		send_tick(4'hE, 4'h0);
		send_tick(4'h1, 4'h0);
		send_tick(4'h3, 4'h0);
		set_enable(1'b0);
		send_tick(4'hF, 4'hF);
		send_tick(4'h0, 4'hF);
		set_enable(1'b1);
		set_threshold(63);
		send_tick(4'h0, 4'h8);
		send_tick(4'h0, 4'hC);
		send_tick(4'h7, 4'hE);

		set_threshold(0);
		run_random(250);
		set_threshold(63);
		long_hold = 1'b1;
		run_random(300);
		set_threshold(62);
		run_random(300);
		set_enable(1'b0);
		run_random(150);
		set_enable(1'b1);
		set_threshold($urandom_range(1, 40));
		run_random(150);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		run_random(150);
		set_threshold(30);
		run_random(300);
		set_threshold($urandom_range(0, 8));
		no_idle = 1'b1;
		run_random(250);

		drain();
		if (sb.errors == 0)
			$display("tb_core_gating_policy OK");
		else
			$display("tb_core_gating_policy NOT OK");
		$finish;
	end
endmodule
